### design/tcce_pkg.sv
package tcce_pkg;

    // Field widths of the request and response words.
    localparam int FUNC_W = 1;
    localparam int CHAR_W = 8;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [ATTR_W-1:0] attr_t;

    // Request function codes.
    localparam logic [FUNC_W-1:0] FUNC_PUT  = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ = 1'b1;

    // Control characters.
    localparam char_t CH_BS    = 8'd8;
    localparam char_t CH_HT    = 8'd9;
    localparam char_t CH_LF    = 8'd10;
    localparam char_t CH_VT    = 8'd11;
    localparam char_t CH_FF    = 8'd12;
    localparam char_t CH_CR    = 8'd13;
    localparam char_t CH_SPACE = 8'h20;

    // Attribute and cell contents after reset.
    localparam attr_t RESET_ATTR = 8'h60;
    localparam cell_t RESET_CELL = {RESET_ATTR, CH_SPACE};

endpackage

### design/tcce_if.sv
// Request channel: one console command or cell read per word.
interface tcce_in_if import tcce_pkg::*;;
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    char_t             char_code;
    logic [ROW_W-1:0]  cell_row;
    logic [COL_W-1:0]  cell_column;

    modport source (output valid, func, char_code, cell_row, cell_column, input ready);
    modport sink   (input valid, func, char_code, cell_row, cell_column, output ready);
endinterface

// Response channel: cell data and cursor position per word.
interface tcce_out_if import tcce_pkg::*;;
    logic             valid;
    logic             ready;
    cell_t            read_data;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_line;

    modport source (output valid, read_data, cursor_col, cursor_line, input ready);
    modport sink   (input valid, read_data, cursor_col, cursor_line, output ready);
endinterface

### design/tcce_ram.sv
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port; read data holds without rd_en.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### design/text_console_char_engine.sv
// Channel | Direction | Word contents
// req     | in        | func, char_code, cell_row, cell_column
// rsp     | out       | read_data, cursor_col, cursor_line
// cfg     | in        | cfg_we, cfg_wdata (text attribute)
//
// A read or a carriage return goes straight to the response state, a printable
// character through a print state, a backspace through a blank state, and a tab
// writes TAB_SPACES spaces, one cell write each on the single cell write port.
// A scroll and a form feed walk the screen memory one cell a cycle with the
// shared address counter; after reset a clearing pass runs before req is ready.
// A stalled response holds its word; the next request is still accepted.
module text_console_char_engine import tcce_pkg::*; #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    parameter int TAB_SPACES     = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    tcce_in_if.sink           req,
    tcce_out_if.source        rsp,
    input  logic              cfg_we,
    input  attr_t             cfg_wdata
);

    localparam int CELLS  = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int MOVED  = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CNT_W  = $clog2(CELLS + 1);
    localparam int X_W    = $clog2(SCREEN_COLUMNS);
    localparam int Y_W    = $clog2(SCREEN_ROWS);
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_PRINT,
        S_BLANK,
        S_SCROLL,
        S_DONE
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [X_W-1:0]     x_reg, x_next;
    logic [Y_W-1:0]     y_reg, y_next;
    char_t              ch_reg, ch_next;
    logic [TAB_W-1:0]   tab_reg, tab_next;
    logic               fill_reset_reg, fill_reset_next;
    logic               rd_hit_reg, rd_hit_next;
    attr_t              attr_reg;
    logic               out_valid_reg, out_valid_next;
    cell_t              out_data_reg, out_data_next;
    logic [COL_W-1:0]   out_col_reg, out_col_next;
    logic [ROW_W-1:0]   out_line_reg, out_line_next;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr;
    cell_t              ram_wdata;
    logic               ram_re;
    logic [ADDR_W-1:0]  ram_raddr;
    cell_t              ram_rdata;

    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  req_addr;
    logic               req_in_range;
    logic               slot_free;
    cell_t              blank_cell;

    // Screen memory, row by row.
    tcce_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Linear addresses of the cursor cell and of the requested cell.
    assign cur_addr     = ADDR_W'(32'(y_reg) * SCREEN_COLUMNS + 32'(x_reg));
    assign req_addr     = ADDR_W'(32'(req.cell_row) * SCREEN_COLUMNS + 32'(req.cell_column));
    assign req_in_range = (32'(req.cell_row) < SCREEN_ROWS)
                        && (32'(req.cell_column) < SCREEN_COLUMNS);
    assign blank_cell   = {attr_reg, CH_SPACE};
    assign slot_free    = !out_valid_reg || rsp.ready;

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.read_data   = out_data_reg;
    assign rsp.cursor_col  = out_col_reg;
    assign rsp.cursor_line = out_line_reg;

    // Sequencer: decodes one request and drives the shared cell counter.
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        ch_next         = ch_reg;
        tab_next        = tab_reg;
        fill_reset_next = fill_reset_reg;
        rd_hit_next     = rd_hit_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_data_next   = out_data_reg;
        out_col_next    = out_col_reg;
        out_line_next   = out_line_reg;
        ram_we          = 1'b0;
        ram_waddr       = cur_addr;
        ram_wdata       = blank_cell;
        ram_re          = 1'b0;
        ram_raddr       = cur_addr;

        case (state_reg)
            S_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg[ADDR_W-1:0];
                ram_wdata = fill_reset_reg ? RESET_CELL : blank_cell;
                if (cnt_reg == CNT_W'(CELLS - 1))
                begin
                    cnt_next   = '0;
                    state_next = fill_reset_reg ? S_IDLE : S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    rd_hit_next = 1'b0;
                    if (req.func == FUNC_READ)
                    begin
                        // The read data arrives next cycle and holds in the RAM.
                        ram_re      = req_in_range;
                        ram_raddr   = req_addr;
                        rd_hit_next = req_in_range;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        case (req.char_code)
                            CH_BS:
                            begin
                                if (x_reg != '0)
                                begin
                                    x_next = x_reg - 1'b1;
                                end
                                else if (y_reg != '0)
                                begin
                                    y_next = y_reg - 1'b1;
                                    x_next = X_W'(SCREEN_COLUMNS - 1);
                                end
                                state_next = S_BLANK;
                            end
                            CH_CR:
                            begin
                                x_next     = '0;
                                state_next = S_DONE;
                            end
                            CH_LF, CH_VT:
                            begin
                                x_next   = '0;
                                tab_next = '0;
                                if (y_reg == Y_W'(SCREEN_ROWS - 1))
                                begin
                                    cnt_next   = '0;
                                    state_next = S_SCROLL;
                                end
                                else
                                begin
                                    y_next     = y_reg + 1'b1;
                                    state_next = S_DONE;
                                end
                            end
                            CH_FF:
                            begin
                                x_next          = '0;
                                y_next          = '0;
                                cnt_next        = '0;
                                fill_reset_next = 1'b0;
                                state_next      = S_FILL;
                            end
                            CH_HT:
                            begin
                                ch_next    = CH_SPACE;
                                tab_next   = TAB_W'(TAB_SPACES);
                                state_next = S_PRINT;
                            end
                            default:
                            begin
                                ch_next    = req.char_code;
                                tab_next   = TAB_W'(1);
                                state_next = S_PRINT;
                            end
                        endcase
                    end
                end
            end

            S_PRINT:
            begin
                // Write one character at the cursor and advance it.
                ram_we    = 1'b1;
                ram_wdata = {attr_reg, ch_reg};
                tab_next  = tab_reg - 1'b1;
                if (x_reg == X_W'(SCREEN_COLUMNS - 1))
                begin
                    x_next = '0;
                    if (y_reg == Y_W'(SCREEN_ROWS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = S_SCROLL;
                    end
                    else
                    begin
                        y_next     = y_reg + 1'b1;
                        state_next = (tab_reg == TAB_W'(1)) ? S_DONE : S_PRINT;
                    end
                end
                else
                begin
                    x_next     = x_reg + 1'b1;
                    state_next = (tab_reg == TAB_W'(1)) ? S_DONE : S_PRINT;
                end
            end

            S_BLANK:
            begin
                ram_we     = 1'b1;
                state_next = S_DONE;
            end

            S_SCROLL:
            begin
                // Read one row ahead, write the cell read in the previous cycle,
                // then blank the last row.
                ram_re    = (cnt_reg < CNT_W'(MOVED));
                ram_raddr = ADDR_W'(cnt_reg + CNT_W'(SCREEN_COLUMNS));
                ram_we    = (cnt_reg != '0);
                ram_waddr = ADDR_W'(cnt_reg - 1'b1);
                ram_wdata = (cnt_reg <= CNT_W'(MOVED)) ? ram_rdata : blank_cell;
                if (cnt_reg == CNT_W'(CELLS))
                begin
                    cnt_next   = '0;
                    state_next = (tab_reg != '0) ? S_PRINT : S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = rd_hit_reg ? ram_rdata : '0;
                    out_col_next   = COL_W'(x_reg);
                    out_line_next  = ROW_W'(y_reg);
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, cursor, attribute and response registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_FILL;
            cnt_reg        <= '0;
            x_reg          <= '0;
            y_reg          <= '0;
            tab_reg        <= '0;
            fill_reset_reg <= 1'b1;
            rd_hit_reg     <= 1'b0;
            attr_reg       <= RESET_ATTR;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            tab_reg        <= tab_next;
            fill_reset_reg <= fill_reset_next;
            rd_hit_reg     <= rd_hit_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        ch_reg       <= ch_next;
        out_data_reg <= out_data_next;
        out_col_reg  <= out_col_next;
        out_line_reg <= out_line_next;
    end

endmodule

### design/tcce_checker.sv
module tcce_checker import tcce_pkg::*; #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    input  logic             req_ready,
    input  logic             rsp_valid,
    input  logic             rsp_ready,
    input  cell_t            rsp_read_data,
    input  logic [COL_W-1:0] rsp_cursor_col,
    input  logic [ROW_W-1:0] rsp_cursor_line
);

    // A pending response word stays until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // A stalled response word keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_read_data) && $stable(rsp_cursor_col)
            && $stable(rsp_cursor_line))
        else $error("response word changed while stalled");

    // Every request leaves the idle state, so ready drops after an accept.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted back to back");

    // The reported cursor is always on the screen.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_cursor_col) < SCREEN_COLUMNS)
            && (32'(rsp_cursor_line) < SCREEN_ROWS))
        else $error("cursor reported off screen");

endmodule

bind text_console_char_engine tcce_checker #(
    .SCREEN_COLUMNS (SCREEN_COLUMNS),
    .SCREEN_ROWS    (SCREEN_ROWS)
) u_tcce_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_read_data   (rsp.read_data),
    .rsp_cursor_col  (rsp.cursor_col),
    .rsp_cursor_line (rsp.cursor_line)
);

### verif/text_console_char_engine_tb.sv
`timescale 1ns / 1ps

module text_console_char_engine_tb import tcce_pkg::*;;

    localparam int COLS  = 80;
    localparam int ROWS  = 25;
    localparam int TABS  = 4;
    localparam int CELLS = COLS * ROWS;
    // A scroll or a clear walks the whole screen; allow that plus some slack.
    localparam int SETTLE_CYCLES = CELLS + 100;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        cell_t            data;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] line;
    } console_rsp_t;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  cfg_we;
    attr_t cfg_wdata;

    tcce_in_if  req_bus ();
    tcce_out_if rsp_bus ();

    text_console_char_engine #(
        .SCREEN_COLUMNS (COLS),
        .SCREEN_ROWS    (ROWS),
        .TAB_SPACES     (TABS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_bus),
        .rsp       (rsp_bus),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the screen, cursor and attribute.
    cell_t screen_model [CELLS];
    int    model_x;
    int    model_y;
    attr_t model_attr;

    console_rsp_t pending_rsp [$];
    int           error_count = 0;

    bit src_idle_on;
    bit sink_idle_on;
    int hold_requests = 0;
    int holds_served  = 0;
    int hold_left     = 0;

    always #5 clk = ~clk;

    function automatic void model_write(int row, int col, char_t ch);
        if (row < ROWS && col < COLS)
            screen_model[row * COLS + col] = {model_attr, ch};
    endfunction

    // Move to the start of the next row; past the bottom the screen scrolls up.
    function automatic void model_next_line();
        int i;
        model_x = 0;
        model_y++;
        if (model_y >= ROWS)
        begin
            for (i = 0; i < (ROWS - 1) * COLS; i++)
                screen_model[i] = screen_model[i + COLS];
            for (i = 0; i < COLS; i++)
                model_write(ROWS - 1, i, CH_SPACE);
            model_y = ROWS - 1;
        end
    endfunction

    function automatic void model_printable(char_t ch);
        model_write(model_y, model_x, ch);
        model_x++;
        if (model_x >= COLS)
            model_next_line();
    endfunction

    // Apply one request word to the shadow state and return the response word.
    function automatic console_rsp_t console_step(logic [FUNC_W-1:0] f, char_t ch,
                                                  logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
        console_rsp_t r;
        int k;
        r.data = '0;
        if (f == FUNC_PUT)
        begin
            case (ch)
                CH_BS:
                begin
                    if (model_x > 0)
                        model_x--;
                    else if (model_y > 0)
                    begin
                        model_y--;
                        model_x = COLS - 1;
                    end
                    model_write(model_y, model_x, CH_SPACE);
                end
                CH_LF, CH_VT:
                    model_next_line();
                CH_HT:
                    for (k = 0; k < TABS; k++)
                        model_printable(CH_SPACE);
                CH_FF:
                begin
                    for (k = 0; k < CELLS; k++)
                        screen_model[k] = {model_attr, CH_SPACE};
                    model_x = 0;
                    model_y = 0;
                end
                CH_CR:
                    model_x = 0;
                default:
                    model_printable(ch);
            endcase
        end
        else if (row < ROWS && col < COLS)
            r.data = screen_model[row * COLS + col];
        r.col  = model_x[COL_W-1:0];
        r.line = model_y[ROW_W-1:0];
        return r;
    endfunction

    // Offer one request word, wait for it to be taken, and record its response.
    task automatic send_word(input logic [FUNC_W-1:0] f, input char_t ch,
                             input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
        while (src_idle_on && $urandom_range(99) < 28)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.func        <= f;
        req_bus.char_code   <= ch;
        req_bus.cell_row    <= row;
        req_bus.cell_column <= col;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        pending_rsp.push_back(console_step(f, ch, row, col));
        @(negedge clk);
    endtask

    // The row and column of a put word are ignored, so they carry noise.
    task automatic put_char(input char_t ch);
        send_word(FUNC_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic read_cell(input int row, input int col);
        send_word(FUNC_READ, char_t'($urandom), row[ROW_W-1:0], col[COL_W-1:0]);
    endtask

    task automatic wait_drain();
        req_bus.valid <= 1'b0;
        @(negedge clk);
        while (pending_rsp.size() != 0)
            @(negedge clk);
    endtask

    // The attribute changes only with the engine idle and its walks finished.
    task automatic write_attr(input attr_t a);
        wait_drain();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= a;
        @(negedge clk);
        cfg_we     <= 1'b0;
        model_attr  = a;
    endtask

    // Mostly text, with reads on the cursor row, anywhere and off screen, and a sprinkling of control codes.
    task automatic random_items(input int n);
        int    pick;
        char_t ch;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 24)
            begin
                if ($urandom_range(9) == 0)
                    read_cell($urandom_range(31), $urandom_range(127));
                else if ($urandom_range(1) == 0)
                    read_cell(model_y, $urandom_range(COLS - 1));
                else
                    read_cell($urandom_range(ROWS - 1), $urandom_range(COLS - 1));
            end
            else if (pick < 30)
                put_char($urandom_range(1) ? CH_LF : CH_VT);
            else if (pick < 33)
                put_char(CH_BS);
            else if (pick < 36)
                put_char(CH_CR);
            else if (pick < 39)
                put_char(CH_HT);
            else if (pick < 40)
                put_char(CH_FF);
            else
            begin
                do
                    ch = char_t'($urandom);
                while (ch >= CH_BS && ch <= CH_CR);
                put_char(ch);
            end
        end
    endtask

    task automatic test_reset_reads();
        read_cell(0, 0);
        read_cell(ROWS - 1, COLS - 1);
        read_cell(ROWS, 0);
        read_cell(31, 127);
        read_cell(3, COLS);
    endtask

    task automatic test_printable_codes();
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h07);
        put_char(8'h0E);
        put_char(8'h41);
        read_cell(0, 1);
    endtask

    task automatic test_control_codes();
        put_char(CH_BS);
        put_char(CH_CR);
        put_char(CH_HT);
        put_char(CH_LF);
        // Backspace from column 0 goes to the last column of the row above.
        put_char(CH_BS);
        put_char(CH_VT);
        put_char(CH_FF);
        // Backspace at home stays put and blanks the home cell.
        put_char(CH_BS);
        read_cell(0, 4);
    endtask

    task automatic test_attribute_phases();
        write_attr(8'h00);
        random_items(180);
        write_attr(8'hFF);
        random_items(180);
        write_attr(attr_t'($urandom));
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        random_items(180);
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
        write_attr(RESET_ATTR);
    endtask

    // The receiver stalls while words keep coming, so the engine backs up.
    task automatic test_backpressure();
        hold_requests++;
        src_idle_on = 1'b0;
        for (int i = 0; i < 30; i++)
            put_char(char_t'($urandom_range(8'h21, 8'h7E)));
        src_idle_on = 1'b1;
        wait_drain();
    endtask

    task automatic test_sender_pause();
        random_items(15);
        wait_drain();
        random_items(15);
    endtask

    // Response side: random stalls plus a long hold on request.
    always @(negedge clk)
    begin
        if (hold_requests != holds_served)
        begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
        end
        else
            rsp_bus.ready <= !(sink_idle_on && $urandom_range(99) < 28);
    end

    // Compare each accepted response word with the oldest prediction.
    always @(posedge clk)
    begin : rsp_check
        console_rsp_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: unexpected response word, expected none, actual %h/%0d/%0d",
                         $time, rsp_bus.read_data, rsp_bus.cursor_col, rsp_bus.cursor_line);
                error_count++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                if (rsp_bus.read_data !== want.data)
                begin
                    $display("%0t: read_data mismatch, expected %h, actual %h",
                             $time, want.data, rsp_bus.read_data);
                    error_count++;
                end
                if (rsp_bus.cursor_col !== want.col)
                begin
                    $display("%0t: cursor_col mismatch, expected %0d, actual %0d",
                             $time, want.col, rsp_bus.cursor_col);
                    error_count++;
                end
                if (rsp_bus.cursor_line !== want.line)
                begin
                    $display("%0t: cursor_line mismatch, expected %0d, actual %0d",
                             $time, want.line, rsp_bus.cursor_line);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        #100_000_000;
        $display("text_console_char_engine_tb: errors");
        $finish;
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_bus.valid       = 1'b0;
        req_bus.func        = FUNC_PUT;
        req_bus.char_code   = '0;
        req_bus.cell_row    = '0;
        req_bus.cell_column = '0;
        src_idle_on         = 1'b1;
        sink_idle_on        = 1'b1;
        model_attr          = RESET_ATTR;
        model_x             = 0;
        model_y             = 0;
        foreach (screen_model[i])
            screen_model[i] = RESET_CELL;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_reads();
        test_printable_codes();
        test_control_codes();
        test_attribute_phases();
        test_backpressure();
        test_sender_pause();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("text_console_char_engine_tb: clean");
        else
            $display("text_console_char_engine_tb: errors");
        $finish;
    end

endmodule
